FILE: hdl/b64d_pkg.sv
package b64d_pkg;

    // Width of the decoded byte counter
    localparam int COUNT_WIDTH = 16;
    // Width of the capacity register and of the reported byte total
    localparam int CAP_REG_W   = 16;
    localparam int TOTAL_W     = 16;
    // Compare width: holds the capacity, the counter limit and a small carry
    localparam int CAP_W       = ((COUNT_WIDTH > CAP_REG_W) ? COUNT_WIDTH : CAP_REG_W) + 1;
    // Results one character can cause: three bytes and a status
    localparam int MAX_RES     = 4;
    localparam int RES_CNT_W   = $clog2(MAX_RES + 1);

    // Special characters
    localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CH_LF    = 8'h0A;  // newline
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;

    // Sextet values of the alphabet ranges
    localparam logic [7:0] SX_LOWER_BASE = 8'd26;
    localparam logic [7:0] SX_DIGIT_BASE = 8'd52;
    localparam logic [5:0] SX_PLUS       = 6'd62;
    localparam logic [5:0] SX_SLASH      = 6'd63;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               is_status;
        t_status            status_code;
        logic [TOTAL_W-1:0] byte_total;
        logic               run_last;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0] slot;
        logic [RES_CNT_W-1:0]  count;
    } t_bundle;

    typedef struct packed {
        logic [RES_CNT_W-1:0] count;
        logic                 free;
    } t_q_status;

    // Map a character to {in_alphabet, sextet}; '=' maps to zero
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b1;
        if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
            v = ch - CH_UP_A;
        end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
            v = (ch - CH_LO_A) + SX_LOWER_BASE;
        end else if (ch >= CH_DIG_0 && ch <= CH_DIG_9) begin
            v = (ch - CH_DIG_0) + SX_DIGIT_BASE;
        end else if (ch == CH_PLUS) begin
            v = {2'b00, SX_PLUS};
        end else if (ch == CH_SLASH) begin
            v = {2'b00, SX_SLASH};
        end else if (ch == CH_PAD) begin
            v = 8'd0;
        end else begin
            ok = 1'b0;
        end
        return {ok, v[5:0]};
    endfunction

endpackage

FILE: hdl/b64d_decode.sv
module b64d_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [b64d_pkg::CAP_REG_W-1:0]      i_cfg_wdata,
    input  logic                                i_step,
    input  logic [7:0]                          i_char,
    input  logic                                i_eom,
    output b64d_pkg::t_bundle                   o_bundle
);

    localparam int CW   = b64d_pkg::COUNT_WIDTH;
    localparam int CPW  = b64d_pkg::CAP_W;
    localparam int TW   = b64d_pkg::TOTAL_W;
    localparam int RCW  = b64d_pkg::RES_CNT_W;

    // Message state
    logic [1:0]                    r_pos;
    logic [5:0]                    r_h [3];
    logic                          r_tp;
    logic                          r_gi;
    logic [CW-1:0]                 r_bw;
    logic                          r_fin;
    b64d_pkg::t_status             r_code;
    logic [b64d_pkg::CAP_REG_W-1:0] r_cap;

    logic [1:0]                    n_pos;
    logic                          n_tp;
    logic                          n_gi;
    logic [CW-1:0]                 n_bw;
    logic                          n_fin;
    b64d_pkg::t_status             n_code;
    logic                          n_hwe;

    logic [6:0]                    sx;
    logic                          sx_ok;
    logic [5:0]                    sx_val;
    logic                          active;
    logic [CPW-1:0]                cap_ext;
    logic [CPW-1:0]                cnt_max;
    logic [CPW-1:0]                cap;
    logic [CPW-1:0]                w_ext;
    logic                          fit1, fit2, fit3;
    logic [1:0]                    fitn;
    logic [1:0]                    wantn;
    logic [1:0]                    nb;
    logic [7:0]                    dec_byte [3];
    logic [CPW-1:0]                tot_sum [3];
    logic [CPW-1:0]                fin_sum;
    b64d_pkg::t_status             eom_code;
    logic [RCW-1:0]                res_cnt;

    // Classify the character and limit the capacity to the counter range
    always_comb begin
        sx      = b64d_pkg::sextet_of(i_char);
        sx_ok   = sx[6];
        sx_val  = sx[5:0];
        active  = !r_fin && !(r_pos == 2'd0 && i_char == b64d_pkg::CH_LF);
        cap_ext = CPW'(r_cap);
        cnt_max = CPW'({CW{1'b1}});
        cap     = (cap_ext < cnt_max) ? cap_ext : cnt_max;
        w_ext   = CPW'(r_bw);
        fit1    = w_ext < cap;
        fit2    = (w_ext + CPW'(1)) < cap;
        fit3    = (w_ext + CPW'(2)) < cap;
        fitn    = fit1 ? (fit2 ? (fit3 ? 2'd3 : 2'd2) : 2'd1) : 2'd0;
        wantn   = r_tp ? 2'd1 : ((i_char == b64d_pkg::CH_PAD) ? 2'd2 : 2'd3);
        dec_byte[0] = {r_h[0], r_h[1][5:4]};
        dec_byte[1] = {r_h[1][3:0], r_h[2][5:2]};
        dec_byte[2] = {r_h[2][1:0], sx_val};
    end

    // Next message state for the character
    always_comb begin
        n_pos  = r_pos;
        n_tp   = r_tp;
        n_gi   = r_gi;
        n_bw   = r_bw;
        n_fin  = r_fin;
        n_code = r_code;
        n_hwe  = 1'b0;
        nb     = 2'd0;
        if (active) begin
            if (r_pos != 2'd3) begin
                n_hwe = 1'b1;
                if (r_pos == 2'd2) begin
                    n_tp = (i_char == b64d_pkg::CH_PAD);
                end
                if (!sx_ok) begin
                    n_gi = 1'b1;
                end
                n_pos = r_pos + 2'd1;
            end else begin
                n_pos = 2'd0;
                n_gi  = 1'b0;
                n_tp  = 1'b0;
                if (r_gi || !sx_ok) begin
                    n_fin  = 1'b1;
                    n_code = b64d_pkg::ST_INVALID;
                end else if (fitn < wantn) begin
                    nb     = fitn;
                    n_fin  = 1'b1;
                    n_code = b64d_pkg::ST_OVERFLOW;
                end else begin
                    nb = wantn;
                    if (wantn != 2'd3) begin
                        n_fin = 1'b1;
                    end
                end
                n_bw = r_bw + CW'(nb);
            end
        end
    end

    // Assemble the results: bytes first, then the status on an end mark
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tot_sum[k] = w_ext + CPW'(k + 1);
        end
        fin_sum  = CPW'(n_bw);
        eom_code = (!n_fin && n_pos != 2'd0) ? b64d_pkg::ST_INVALID : n_code;
        res_cnt  = RCW'(nb) + RCW'(i_eom);
        o_bundle.count = res_cnt;
        for (int i = 0; i < b64d_pkg::MAX_RES; i++) begin
            if (i < 3 && RCW'(i) < RCW'(nb)) begin
                o_bundle.slot[i].out_byte    = dec_byte[(i < 3) ? i : 0];
                o_bundle.slot[i].is_status   = 1'b0;
                o_bundle.slot[i].status_code = b64d_pkg::ST_OK;
                o_bundle.slot[i].byte_total  = tot_sum[(i < 3) ? i : 0][TW-1:0];
            end else begin
                o_bundle.slot[i].out_byte    = 8'd0;
                o_bundle.slot[i].is_status   = 1'b1;
                o_bundle.slot[i].status_code = eom_code;
                o_bundle.slot[i].byte_total  = fin_sum[TW-1:0];
            end
            o_bundle.slot[i].run_last = (RCW'(i + 1) == res_cnt);
        end
    end

    // Hold the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= {b64d_pkg::CAP_REG_W{1'b1}};
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Advance the message state; an end mark starts a fresh message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_tp   <= 1'b0;
            r_gi   <= 1'b0;
            r_bw   <= '0;
            r_fin  <= 1'b0;
            r_code <= b64d_pkg::ST_OK;
        end else if (i_step) begin
            if (i_eom) begin
                r_pos  <= 2'd0;
                r_tp   <= 1'b0;
                r_gi   <= 1'b0;
                r_bw   <= '0;
                r_fin  <= 1'b0;
                r_code <= b64d_pkg::ST_OK;
            end else begin
                r_pos  <= n_pos;
                r_tp   <= n_tp;
                r_gi   <= n_gi;
                r_bw   <= n_bw;
                r_fin  <= n_fin;
                r_code <= n_code;
            end
        end
    end

    // Store the sextet of the first three places
    always_ff @(posedge i_clk) begin
        if (i_step && n_hwe) begin
            case (r_pos)
                2'd0:    r_h[0] <= sx_val;
                2'd1:    r_h[1] <= sx_val;
                2'd2:    r_h[2] <= sx_val;
                default: r_h[0] <= r_h[0];
            endcase
        end
    end

endmodule

FILE: hdl/b64d_out_q.sv
module b64d_out_q (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  b64d_pkg::t_bundle     i_bundle,
    input  logic                  i_tready,
    output logic                  o_tvalid,
    output b64d_pkg::t_result     o_result,
    output b64d_pkg::t_q_status   o_status
);

    localparam int RCW = b64d_pkg::RES_CNT_W;

    b64d_pkg::t_result [b64d_pkg::MAX_RES-1:0] r_slot;
    logic [RCW-1:0]                            r_cnt;
    logic                                      take;

    // Drain one result per transaction from the head slot
    always_comb begin
        take            = (r_cnt != '0) && i_tready;
        o_tvalid        = (r_cnt != '0);
        o_result        = r_slot[0];
        o_status.count  = r_cnt;
        o_status.free   = (r_cnt == '0) || (r_cnt == RCW'(1) && i_tready);
    end

    // Count the results still held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_bundle.count;
        end else if (take) begin
            r_cnt <= r_cnt - RCW'(1);
        end
    end

    // Load a new bundle or shift the remaining results toward the head
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.slot;
        end else if (take) begin
            for (int k = 0; k < b64d_pkg::MAX_RES - 1; k++) begin
                r_slot[k] <= r_slot[k + 1];
            end
        end
    end

endmodule

FILE: hdl/base64_stream_decoder.sv
// Base64 stream decoder. Takes one ASCII character per transaction on the
// slave side (tlast marks the last character of a message) and returns decoded
// bytes and one final status per message on the master side (tuser high on the
// status, tlast high on the last result caused by a character). A character is
// accepted every cycle unless the held one waits for room; it is registered,
// decoded from that register and its results move into a four-entry result
// buffer that drains one result per cycle while the master side is ready, so
// a group's bytes after the first follow one per cycle. The fourth character of
// a group can cause three bytes plus a status; a later character that causes
// results waits until that buffer is empty or its last entry is being taken;
// characters with no result keep flowing. Status codes: 0 ok, 1 invalid or
// truncated input, 2 output capacity exceeded. The capacity register resets
// to 65535; the user must write it only while idle; the block does not enforce it.
module base64_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_char
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] out_byte, [9:8] status_code,
                                          // [25:10] byte_total, [31:26] zero
    output logic        o_m_axis_tuser,   // [0] is_status
    output logic        o_m_axis_tlast
);

    logic                  r_in_v;
    logic [7:0]            r_in_char;
    logic                  r_in_eom;
    logic                  move;
    logic                  load;
    b64d_pkg::t_bundle     bundle;
    b64d_pkg::t_result     res;
    b64d_pkg::t_q_status   q_status;

    // Decode the held character when its results have room
    assign move            = r_in_v && (bundle.count == '0 || q_status.free);
    assign load            = move && (bundle.count != '0);
    assign o_s_axis_tready = !r_in_v || move;

    // Hold the incoming character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
            r_in_eom  <= i_s_axis_tlast;
        end
    end

    b64d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (move),
        .i_char      (r_in_char),
        .i_eom       (r_in_eom),
        .o_bundle    (bundle)
    );

    b64d_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (bundle),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_result (res),
        .o_status (q_status)
    );

    // Pack the result transaction
    assign o_m_axis_tdata = {6'd0, res.byte_total, res.status_code, res.out_byte};
    assign o_m_axis_tuser = res.is_status;
    assign o_m_axis_tlast = res.run_last;

`ifndef SYNTHESIS
    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (q_status.count == '0 ||
                  (q_status.count == 1 && i_m_axis_tready)))
        else $error("result buffer loaded while still holding results");

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("status result is not the last of its run");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= b64d_pkg::MAX_RES)
        else $error("result buffer count out of range");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_v)
        else $error("input stalled with an empty input register");
`endif

endmodule
